[hdl/z_order_range_query_scheduler_top_macros.svh]
// Assertion macros for the range-query scheduler checker.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef Z_ORDER_RANGE_QUERY_SCHEDULER_TOP_MACROS_SVH
`define Z_ORDER_RANGE_QUERY_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define ZOQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zoqs: same-cycle property violated");

// Next-cycle implication.
`define ZOQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zoqs: next-cycle property violated");

`endif

[hdl/zoqs_pkg.sv]
`default_nettype none

package zoqs_pkg;

  localparam int OP_W   = 2;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 16;
  localparam int POS_W  = 16;
  localparam int ID_W   = 8;
  localparam int WIN_W  = 17;
  localparam int KEY_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_ANSWER = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  // Source of the next output result.
  typedef enum logic [1:0] {
    OSEL_REJECT = 2'd0,
    OSEL_DONE   = 2'd1,
    OSEL_STEP   = 2'd2
  } osel_t;

  typedef struct packed {
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
    logic [ID_W-1:0]  id;
  } zoqs_entry_t;

  typedef struct packed {
    logic  capture;    // latch load request, open hole at table end
    logic  clear;      // empty the batch
    logic  ins_read;   // read entry just below the hole
    logic  ins_shift;  // move read entry up into the hole, read next one down
    logic  ins_place;  // write new query into the hole, bump count
    logic  tick_read;  // read entry at sweep cursor
    logic  out_load;   // load output register
    osel_t out_sel;
  } zoqs_cmd_t;

  typedef struct packed {
    logic load_bad;    // live load request must be rejected
    logic sweep_done;  // cursor has reached the count
    logic count_zero;
    logic key_gt;      // read entry key above new key
    logic hole_one;
    logic out_free;
  } zoqs_status_t;

  // Bit-interleave: x bit i to key bit 2i, y bit i to key bit 2i+1.
  function automatic logic [KEY_W-1:0] morton(input logic [VAL_W-1:0] x,
                                              input logic [VAL_W-1:0] y,
                                              input int unsigned pairs);
    logic [KEY_W-1:0] z;
    z = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (i < pairs) begin
        z[2*i]   = x[i];
        z[2*i+1] = y[i];
      end
    end
    return z;
  endfunction

endpackage

`default_nettype wire

[hdl/z_order_range_query_scheduler_top.sv]
// Channel   Dir  Handshake          tuser           tdata (low bit up)
// s_*       in   s_tvalid/s_tready  op[1:0]         left[15:0], right[31:16]
// m_*       out  m_tvalid/m_tready  kind[2:0]       position[15:0], query_id[23:16]
//
// Requests: clear and the unused op finish in the idle state; a tick and a
// rejected load go on to emit a result. A load into an empty table places the
// query at once, else each entry whose key is above the new key is shifted up
// before the query is placed. The query table has a registered read.
// Reset (rst, synchronous): empty batch, window [0,0), no pending result.
// A stalled result holds in the output register; the next request is still
// taken, and its own result waits until the register frees up.
`default_nettype none

module z_order_range_query_scheduler_top #(
  parameter int unsigned MAX_QUERIES = 256,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left[15:0], right[31:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // position[15:0], query_id[23:16]
  output logic [2:0]  m_tuser    // kind[2:0]
);
  import zoqs_pkg::*;

  // Command and status between sequencer and datapath
  zoqs_cmd_t        cmd;
  zoqs_status_t     status;

  kind_t            out_kind;
  logic [POS_W-1:0] out_pos;
  logic [ID_W-1:0]  out_id;

  // Sequencer: decode requests, step the sorted insert, time result loads
  zoqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: query table memory, batch counters, window and output register
  zoqs_dp #(
    .MAX_QUERIES (MAX_QUERIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_left   (s_tdata[15:0]),
    .in_right  (s_tdata[31:16]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_kind  (out_kind),
    .out_pos   (out_pos),
    .out_id    (out_id)
  );

  // Pack result fields, lowest field first
  assign m_tdata = {out_id, out_pos};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire

[hdl/zoqs_ctrl.sv]
`default_nettype none

module zoqs_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic [1:0]                op,
  output logic                      s_tready,
  input  zoqs_pkg::zoqs_status_t    status,
  output zoqs_pkg::zoqs_cmd_t       cmd
);
  import zoqs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_EMIT
  } state_t;

  state_t state, state_next;
  osel_t  osel, osel_next;
  op_t    op_code;

  assign op_code  = op_t'(op);
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    osel_next  = osel;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (op_code)
            OP_LOAD: begin
              if (status.load_bad) begin
                osel_next  = OSEL_REJECT;
                state_next = ST_EMIT;
              end else begin
                cmd.capture = 1'b1;
                state_next  = status.count_zero ? ST_INS_PUT : ST_INS_RD;
              end
            end
            OP_TICK: begin
              if (status.sweep_done) begin
                osel_next = OSEL_DONE;
              end else begin
                cmd.tick_read = 1'b1;
                osel_next     = OSEL_STEP;
              end
              state_next = ST_EMIT;
            end
            OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_INS_RD: begin
        cmd.ins_read = 1'b1;
        state_next   = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (status.key_gt) begin
          cmd.ins_shift = 1'b1;
          if (status.hole_one) state_next = ST_INS_PUT;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        cmd.ins_place = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = osel;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      osel  <= OSEL_DONE;
    end else begin
      state <= state_next;
      osel  <= osel_next;
    end
  end

endmodule

`default_nettype wire

[hdl/zoqs_dp.sv]
`default_nettype none

module zoqs_dp #(
  parameter int unsigned MAX_QUERIES = 256,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [zoqs_pkg::VAL_W-1:0]    in_left,
  input  logic [zoqs_pkg::VAL_W-1:0]    in_right,
  input  zoqs_pkg::zoqs_cmd_t           cmd,
  output zoqs_pkg::zoqs_status_t        status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output zoqs_pkg::kind_t               out_kind,
  output logic [zoqs_pkg::POS_W-1:0]    out_pos,
  output logic [zoqs_pkg::ID_W-1:0]     out_id
);
  import zoqs_pkg::*;

  localparam int CW = $clog2(MAX_QUERIES + 1);
  localparam int AW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;

  zoqs_entry_t mem [MAX_QUERIES];
  zoqs_entry_t rd_data;
  zoqs_entry_t new_entry;
  zoqs_entry_t wr_data;

  logic [CW-1:0]    count, cursor, hole, hole_m1, hole_m2;
  logic [WIN_W-1:0] wb, we;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr;

  // Sweep step results
  logic [WIN_W-1:0] ql_x, qr_x, qr_p1, wb_dec, we_dec;
  logic [WIN_W-1:0] wb_step, we_step;
  logic [CW-1:0]    cursor_step;
  kind_t            step_kind;
  logic [POS_W-1:0] step_pos;
  logic [ID_W-1:0]  step_id;
  logic             step_fire;

  kind_t            osel_kind;
  logic [POS_W-1:0] osel_pos;
  logic [ID_W-1:0]  osel_id;

  assign hole_m1 = hole - CW'(1);
  assign hole_m2 = hole - CW'(2);

  // Table port: one read, one write per cycle
  assign rd_en   = cmd.ins_read | cmd.ins_shift | cmd.tick_read;
  assign rd_addr = cmd.tick_read ? cursor[AW-1:0] :
                   cmd.ins_shift ? hole_m2[AW-1:0] : hole_m1[AW-1:0];
  assign wr_en   = cmd.ins_shift | cmd.ins_place;
  assign wr_data = cmd.ins_shift ? rd_data : new_entry;

  always_ff @(posedge clk) begin
    if (wr_en) mem[hole[AW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign status.load_bad   = (in_left > in_right) || (count >= CW'(MAX_QUERIES)) ||
                             (cursor != '0);
  assign status.sweep_done = (cursor >= count);
  assign status.count_zero = (count == '0);
  assign status.key_gt     = morton(rd_data.left, rd_data.right, INDEX_BITS) >
                             morton(new_entry.left, new_entry.right, INDEX_BITS);
  assign status.hole_one   = (hole == CW'(1));
  assign status.out_free   = !out_valid || out_ready;

  // One window move by fixed priority, else answer
  assign ql_x   = {1'b0, rd_data.left};
  assign qr_x   = {1'b0, rd_data.right};
  assign qr_p1  = qr_x + WIN_W'(1);
  assign wb_dec = wb - WIN_W'(1);
  assign we_dec = we - WIN_W'(1);

  always_comb begin
    wb_step     = wb;
    we_step     = we;
    cursor_step = cursor;
    step_kind   = KIND_ADD;
    step_pos    = '0;
    step_id     = '0;
    if (wb > ql_x) begin
      wb_step  = wb_dec;
      step_pos = wb_dec[POS_W-1:0];
    end else if (we <= qr_x) begin
      we_step  = we + WIN_W'(1);
      step_pos = we[POS_W-1:0];
    end else if (wb < ql_x) begin
      wb_step   = wb + WIN_W'(1);
      step_kind = KIND_REMOVE;
      step_pos  = wb[POS_W-1:0];
    end else if (we > qr_p1) begin
      we_step   = we_dec;
      step_kind = KIND_REMOVE;
      step_pos  = we_dec[POS_W-1:0];
    end else begin
      cursor_step = cursor + CW'(1);
      step_kind   = KIND_ANSWER;
      step_id     = rd_data.id;
    end
  end

  assign step_fire = cmd.out_load && (cmd.out_sel == OSEL_STEP);

  always_comb begin
    osel_kind = KIND_DONE;
    osel_pos  = '0;
    osel_id   = '0;
    unique case (cmd.out_sel)
      OSEL_REJECT: osel_kind = KIND_REJECT;
      OSEL_DONE:   osel_kind = KIND_DONE;
      OSEL_STEP: begin
        osel_kind = step_kind;
        osel_pos  = step_pos;
        osel_id   = step_id;
      end
      default: osel_kind = KIND_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      wb        <= '0;
      we        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count  <= '0;
        cursor <= '0;
        wb     <= '0;
        we     <= '0;
      end
      if (cmd.ins_place) count <= count + CW'(1);
      if (step_fire) begin
        wb     <= wb_step;
        we     <= we_step;
        cursor <= cursor_step;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hole            <= count;
      new_entry.left  <= in_left;
      new_entry.right <= in_right;
      new_entry.id    <= ID_W'(count);
    end else if (cmd.ins_shift) begin
      hole <= hole_m1;
    end
    if (cmd.out_load) begin
      out_kind <= osel_kind;
      out_pos  <= osel_pos;
      out_id   <= osel_id;
    end
  end

endmodule

`default_nettype wire

[hdl/zoqs_checker.sv]
`default_nettype none

`include "z_order_range_query_scheduler_top_macros.svh"

module zoqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import zoqs_pkg::*;

  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  // Stalled result holds
  `ZOQS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Only add and remove carry a position
  `ZOQS_ASSERT_NOW(a_pos_zero, m_tvalid && (m_tuser == KIND_ANSWER || m_tuser == KIND_DONE || m_tuser == KIND_REJECT), m_tdata[15:0] == 16'd0)

  // Only answer carries a query id
  `ZOQS_ASSERT_NOW(a_id_zero, m_tvalid && m_tuser != KIND_ANSWER, m_tdata[23:16] == 8'd0)

  // A tick always produces a result, so the input side pauses
  `ZOQS_ASSERT_NEXT(a_tick_busy, s_fire && s_tuser == OP_TICK, !s_tready)

  // Clear leaves the input side ready again in the cycle after it is taken
  `ZOQS_ASSERT_NEXT(a_clear_fast, s_fire && s_tuser == OP_CLEAR, s_tready)

endmodule

bind z_order_range_query_scheduler_top zoqs_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sweep_command_checker.sv]
module sweep_command_checker
  import zoqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [31:0]       s_tdata,   // left[15:0], right[31:16]
  input  logic [1:0]        s_tuser,   // op[1:0]
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,   // position[15:0], query_id[23:16]
  input  logic [2:0]        m_tuser,   // kind[2:0]
  output int unsigned       errors,
  output int unsigned       pending
);

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned PAIR_COUNT  = 16;

  typedef struct {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic [ID_W-1:0]  query_id;
  } command_t;

  typedef struct {
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
    logic [ID_W-1:0]  id;
  } query_t;

  query_t           sorted_queries[TABLE_DEPTH];
  int unsigned      loaded;
  int unsigned      cursor;
  logic [WIN_W-1:0] win_lo;
  logic [WIN_W-1:0] win_hi;
  command_t         expected_cmds[$];
  int unsigned      results_seen;

  function automatic logic [KEY_W-1:0] z_key(input logic [VAL_W-1:0] x,
                                             input logic [VAL_W-1:0] y);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < PAIR_COUNT; b++) begin
      k[2*b]   = x[b];
      k[2*b+1] = y[b];
    end
    return k;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] result %0d: %s", $time, results_seen, what);
  endtask

  // Work out the command one request causes, if any, and advance the shadow state.
  task automatic predict_command(input logic [OP_W-1:0] op,
                                 input logic [VAL_W-1:0] l,
                                 input logic [VAL_W-1:0] r);
    command_t         c;
    int unsigned      slot;
    logic [VAL_W-1:0] ql;
    logic [VAL_W-1:0] qr;
    c = '{KIND_DONE, '0, '0};
    if (op == OP_LOAD) begin
      if (l > r || loaded >= TABLE_DEPTH || cursor != 0) begin
        c.kind = KIND_REJECT;
        expected_cmds.push_back(c);
      end else begin
        // equal keys go after the ones already there
        slot = 0;
        while (slot < loaded &&
               z_key(sorted_queries[slot].left, sorted_queries[slot].right) <= z_key(l, r))
          slot++;
        for (int unsigned k = loaded; k > slot; k--)
          sorted_queries[k] = sorted_queries[k-1];
        sorted_queries[slot] = '{l, r, ID_W'(loaded)};
        loaded++;
      end
    end else if (op == OP_TICK) begin
      if (cursor < loaded) begin
        ql = sorted_queries[cursor].left;
        qr = sorted_queries[cursor].right;
        if (win_lo > ql) begin
          win_lo     = win_lo - 1'b1;
          c.kind     = KIND_ADD;
          c.position = win_lo[POS_W-1:0];
        end else if (win_hi <= qr) begin
          c.kind     = KIND_ADD;
          c.position = win_hi[POS_W-1:0];
          win_hi     = win_hi + 1'b1;
        end else if (win_lo < ql) begin
          c.kind     = KIND_REMOVE;
          c.position = win_lo[POS_W-1:0];
          win_lo     = win_lo + 1'b1;
        end else if (win_hi > {1'b0, qr} + 1'b1) begin
          win_hi     = win_hi - 1'b1;
          c.kind     = KIND_REMOVE;
          c.position = win_hi[POS_W-1:0];
        end else begin
          c.kind     = KIND_ANSWER;
          c.query_id = sorted_queries[cursor].id;
          cursor++;
        end
      end
      expected_cmds.push_back(c);
    end else if (op == OP_CLEAR) begin
      loaded = 0;
      cursor = 0;
      win_lo = '0;
      win_hi = '0;
    end
  endtask

  task automatic check_command();
    command_t want;
    results_seen++;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d position %0d id %0d",
                                m_tuser, m_tdata[15:0], m_tdata[23:16]));
      return;
    end
    want = expected_cmds.pop_front();
    if (m_tuser != want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
    if (m_tdata[15:0] != want.position)
      report_mismatch($sformatf("position %0d, want %0d", m_tdata[15:0], want.position));
    if (m_tdata[23:16] != want.query_id)
      report_mismatch($sformatf("query_id %0d, want %0d", m_tdata[23:16], want.query_id));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loaded       = 0;
      cursor       = 0;
      win_lo       = '0;
      win_hi       = '0;
      errors       = 0;
      results_seen = 0;
      expected_cmds.delete();
    end else begin
      // results first: a request never answers in its own cycle
      if (m_tvalid && m_tready) check_command();
      if (s_tvalid && s_tready) predict_command(s_tuser, s_tdata[15:0], s_tdata[31:16]);
    end
    pending <= expected_cmds.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import zoqs_pkg::*;

  // The one op code the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned CALM_ITEMS   = 150;   // tail run with no idling at all
  // A load into a nearly full table holds s_tready low while it shifts the entries.
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned NEVER        = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // left[15:0], right[31:16]
  logic [1:0]  s_tuser;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // position[15:0], query_id[23:16]
  logic [2:0]  m_tuser;   // kind[2:0]

  int unsigned errors;
  int unsigned pending;
  int unsigned stalled_cycles;
  int unsigned sent;            // accepted requests the block acts on
  bit          calm;            // set for the tail: no gaps, no stalls
  int unsigned gap_odds   = 4;  // 1 in gap_odds requests starts after a gap
  int unsigned stall_odds = 4;  // 1 in stall_odds cycles starts a stall

  always #5 clk = ~clk;

  z_order_range_query_scheduler_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sweep_command_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    wait (stalled_cycles >= IDLE_LIMIT);
    $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: drop m_tready at random, in bursts.
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(1, stall_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the block takes it. An idle burst may
  // come first; tdata carries junk while tvalid is low.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [VAL_W-1:0] l,
                              input logic [VAL_W-1:0] r);
    if (!calm && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
    if (op != OP_UNUSED) sent++;
  endtask

  // Ticks carry random bounds, which the block must not look at.
  task automatic tick_sweep(input int unsigned n);
    repeat (n) send_request(OP_TICK, $urandom, $urandom);
  endtask

  // Hold off the sender until every predicted command has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One batch: clear, load a handful of queries (mostly small and valid, some
  // bad, some huge, a little noise), then sweep with enough ticks to finish
  // in most cases, sometimes with a load dropped in mid-sweep.
  task automatic run_batch(input int unsigned queries, input int unsigned span);
    int unsigned      roll;
    int unsigned      budget;
    int unsigned      first;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    send_request(OP_CLEAR, $urandom, $urandom);
    for (int q = 0; q < queries; q++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        a = $urandom;
        b = $urandom;
      end else if (roll == 1) begin
        a = $urandom_range(1, span);
        b = a - 1'b1;
      end else begin
        a = $urandom_range(0, span);
        b = a + $urandom_range(0, span);
      end
      if (roll == 2) send_request(OP_UNUSED, $urandom, $urandom);
      send_request(OP_LOAD, a, b);
    end
    budget = queries * (4 * span + 2) + $urandom_range(0, 6);
    first  = $urandom_range(0, budget);
    tick_sweep(first);
    if ($urandom_range(0, 2) == 0) begin
      a = $urandom_range(0, span);
      send_request(OP_LOAD, a, a + $urandom_range(0, span));
    end
    tick_sweep(budget - first);
  endtask

  // Pick how hard each side idles for the coming batch.
  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        gap_odds   = 3;
        stall_odds = 3;
      end
      1: begin
        gap_odds   = 2;
        stall_odds = NEVER;
      end
      2: begin
        gap_odds   = NEVER;
        stall_odds = 2;
      end
      default: begin
        gap_odds   = NEVER;
        stall_odds = NEVER;
      end
    endcase
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty sweep, bad bounds, bound extremes, equal keys, noise op,
    // a short sweep, a load after the sweep has started, then clear.
    tick_sweep(1);
    send_request(OP_LOAD, 16'hFFFF, 16'h0000);
    send_request(OP_LOAD, 16'h0001, 16'h0000);
    send_request(OP_LOAD, 16'h0000, 16'hFFFF);
    send_request(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_request(OP_LOAD, 16'h0000, 16'h0000);
    send_request(OP_LOAD, 16'h5555, 16'hAAAA);
    send_request(OP_LOAD, 16'hAAAA, 16'h5555);
    send_request(OP_LOAD, 16'h0003, 16'h0007);
    send_request(OP_LOAD, 16'h0003, 16'h0007);
    send_request(OP_LOAD, 16'h0002, 16'h0002);
    send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    tick_sweep(8);
    send_request(OP_LOAD, 16'h0001, 16'h0001);
    tick_sweep(4);
    send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    tick_sweep(1);

    // Fill the table to the brim with tiny, often equal queries, then try one
    // more. Start from a quiet block.
    drain_results();
    send_request(OP_CLEAR, $urandom, $urandom);
    for (int q = 0; q < TABLE_DEPTH; q++) begin
      logic [VAL_W-1:0] a;
      a = $urandom_range(0, 3);
      send_request(OP_LOAD, a, a + $urandom_range(0, 3));
    end
    send_request(OP_LOAD, 16'h0000, 16'h0000);
    tick_sweep(40);

    // Random batches, mostly small sizes; the tail runs with no idling.
    while (sent < ITEM_TARGET) begin
      if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      pick_idling();
      if ($urandom_range(0, 9) == 0) run_batch($urandom_range(1, 2), 40);
      else run_batch($urandom_range(1, 6), $urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
